// ===== src/page_frame_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PFA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PFA_ASSERT(lbl, prop, msg)
`define PFA_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// sizes, codes, shared types and helpers of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int MAX_PAGES  = 65536;
	localparam int PAGE_SHIFT = 12;

	localparam int CFG_W   = 17;
	localparam int PG_W    = 17;
	localparam int RUN_W   = PG_W + 1;
	localparam int NEED_W  = 33 - PAGE_SHIFT;
	localparam int FW      = 34 - PAGE_SHIFT;
	localparam int WORD_W  = (MAX_PAGES >= 64) ? 32 : 8;
	localparam int WB      = $clog2(WORD_W);
	localparam int WORDS   = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW      = $clog2(WORDS);
	localparam int ADDR_PG = 2 ** (32 - PAGE_SHIFT);
	localparam int WIN_MAX = (MAX_PAGES < ADDR_PG) ? MAX_PAGES : ADDR_PG;

	localparam int PAGES_RST = 65536;
	localparam int FIRST_RST = 256;
	localparam int WIN_RST   = (PAGES_RST < WIN_MAX) ? PAGES_RST : WIN_MAX;
	localparam int FREE_RST  = (WIN_RST > FIRST_RST) ? WIN_RST - FIRST_RST : 0;

	localparam logic CFG_PAGES = 1'b0;
	localparam logic CFG_FIRST = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_NOMEM   = 2'd2
	} status_t;

	typedef struct packed {
		logic             hit;
		logic [WB-1:0]    pos;
		logic [RUN_W-1:0] carry;
	} scan_res_t;

	function automatic logic [AW-1:0] page_word(input logic [PG_W-1:0] p);
		return AW'(p >> WB);
	endfunction

	// bit j set when page {w, j} lies in [a, b)
	function automatic logic [WORD_W-1:0] range_mask(input logic [AW-1:0] w,
			input logic [PG_W-1:0] a, input logic [PG_W-1:0] b);
		logic [31:0]       g;
		logic [WORD_W-1:0] m;
		m = '0;
		for (int j = 0; j < WORD_W; j++) begin
			g = (32'(w) << WB) | 32'(j);
			m[j] = (g >= 32'(a)) && (g < 32'(b));
		end
		return m;
	endfunction

endpackage

// ===== src/pfa_scan.sv =====
// ----------------------------------------------------------------------------
// pfa_scan
// first fit search over one map word, carrying the free run from the word below
// ----------------------------------------------------------------------------
module pfa_scan import pfa_pkg::*; (
	input  logic [WORD_W-1:0] data,
	input  logic [AW-1:0]     word,
	input  logic [PG_W-1:0]   lo,
	input  logic [PG_W-1:0]   hi,
	input  logic [RUN_W-1:0]  carry,
	input  logic [NEED_W-1:0] need,
	output scan_res_t         res
);

	always_comb begin
		logic [WORD_W-1:0] f;
		logic              allf;
		logic [WB-1:0]     lastz;
		logic [RUN_W-1:0]  run;
		// pages outside the window count as taken
		f = ~data & range_mask(word, lo, hi);
		allf = 1'b1;
		lastz = '0;
		res.hit = 1'b0;
		res.pos = '0;
		for (int j = 0; j < WORD_W; j++) begin
			allf = allf & f[j];
			if (!f[j]) begin
				lastz = WB'(j);
			end
			run = allf ? carry + RUN_W'(j + 1) : RUN_W'(j) - RUN_W'(lastz);
			if (!res.hit && f[j] && (32'(run) >= 32'(need))) begin
				res.hit = 1'b1;
				res.pos = WB'(j);
			end
		end
		res.carry = allf ? carry + RUN_W'(WORD_W) : RUN_W'(WORD_W - 1) - RUN_W'(lastz);
	end

endmodule

// ===== src/page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_core
// first fit page frame allocator over a one bit per page map held in a
// word wide synchronous memory, with a free page counter
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode, tdata size, base
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser status, tdata addr, free
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  one map word per cycle through the one read port and the one write port of the map
//  alloc scans map words until a free run fits, then marks the words of that run
//  free clears the words in the released range; reinit rewrites every map word
//  after reset a rebuild pass over every map word runs before the first request
//  a request is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module page_frame_allocator_core import pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // size_bytes[31:0], page_base[63:32]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // first_address[31:0], free_pages[48:32], zeros
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_SETUP,
		S_WALK,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		M_SCAN,
		M_SET,
		M_CLRB
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [CFG_W-1:0]  pages_q;
	logic [CFG_W-1:0]  first_q;
	logic [PG_W-1:0]   free_q;
	logic [PG_W-1:0]   sf_q;
	logic [PG_W-1:0]   sn_q;
	logic [AW-1:0]     wcnt_q;
	logic              init_resp_q;
	opcode_t           op_q;
	logic [NEED_W-1:0] need_q;
	logic [31:0]       base_q;
	logic [PG_W-1:0]   lo_q;
	logic [PG_W-1:0]   hi_q;
	logic [PG_W-1:0]   start_q;
	logic [AW-1:0]     rd_addr_q;
	logic [AW-1:0]     end_addr_q;
	logic              rd_go_q;
	logic [RUN_W-1:0]  carry_q;
	logic              v_s1;
	logic [AW-1:0]     w_s1;
	logic [WORD_W-1:0] rd_data_s1;
	logic [31:0]       res_addr_q;
	status_t           res_st_q;
	logic              m_valid_q;
	logic [31:0]       m_addr_q;
	status_t           m_st_q;
	logic [PG_W-1:0]   m_free_q;

	logic [WORD_W-1:0] map_mem [WORDS];

	logic [PG_W-1:0]   win;
	logic [PG_W-1:0]   lo_alloc;
	logic [WORD_W-1:0] wmask;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	scan_res_t         scan;
	logic              redirect;
	logic              walk_last;
	logic [PG_W-1:0]   hit_idx;
	logic [PG_W-1:0]   hit_start;
	logic [PG_W-1:0]   pop;
	logic [FW-1:0]     fp_w;
	logic [FW-1:0]     lp_w;
	logic [FW-1:0]     lc_w;
	logic [FW-1:0]     fc_w;
	logic [NEED_W-1:0] need_in;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_free_q, m_addr_q};
	assign m_axis_tuser  = m_st_q;

	assign win = (32'(pages_q) > 32'(WIN_MAX)) ? PG_W'(WIN_MAX) : pages_q;
	assign lo_alloc = (first_q == '0) ? PG_W'(1) : first_q;
	assign need_in = NEED_W'((33'(s_axis_tdata[31:0]) + 33'((1 << PAGE_SHIFT) - 1))
		>> PAGE_SHIFT);

	// free range clipped to the window and the reserved floor
	assign fp_w = FW'(base_q >> PAGE_SHIFT);
	assign lp_w = fp_w + FW'(need_q);
	assign lc_w = (lp_w < FW'(win)) ? lp_w : FW'(win);
	assign fc_w = (fp_w > FW'(first_q)) ? fp_w : FW'(first_q);

	assign wmask = range_mask(w_s1, lo_q, hi_q);
	assign walk_last = v_s1 && (w_s1 == end_addr_q);
	assign hit_idx = PG_W'({w_s1, scan.pos});
	assign hit_start = hit_idx + PG_W'(1) - PG_W'(need_q);
	assign redirect = (state_q == S_WALK) && v_s1 && (mode_q == M_SCAN) && scan.hit;

	pfa_scan u_scan (
		.data  (rd_data_s1),
		.word  (w_s1),
		.lo    (lo_q),
		.hi    (hi_q),
		.carry (carry_q),
		.need  (need_q),
		.res   (scan)
	);

	always_comb begin
		logic [WB:0] cnt;
		cnt = '0;
		for (int j = 0; j < WORD_W; j++) begin
			cnt = cnt + (WB + 1)'(rd_data_s1[j] & wmask[j]);
		end
		pop = PG_W'(cnt);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wcnt_q;
		mem_wd = ~range_mask(wcnt_q, sf_q, sn_q);
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
		end else if (state_q == S_WALK && v_s1 && mode_q != M_SCAN) begin
			mem_we = 1'b1;
			mem_wa = w_s1;
			mem_wd = (mode_q == M_SET) ? (rd_data_s1 | wmask) : (rd_data_s1 & ~wmask);
		end
		mem_re = (state_q == S_WALK) && rd_go_q;
		mem_ra = rd_addr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= map_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			mode_q      <= M_SCAN;
			pages_q     <= CFG_W'(PAGES_RST);
			first_q     <= CFG_W'(FIRST_RST);
			free_q      <= PG_W'(FREE_RST);
			sf_q        <= PG_W'(FIRST_RST);
			sn_q        <= PG_W'(WIN_RST);
			wcnt_q      <= '0;
			init_resp_q <= 1'b0;
			op_q        <= OP_NOP;
			need_q      <= '0;
			base_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			start_q     <= '0;
			rd_addr_q   <= '0;
			end_addr_q  <= '0;
			rd_go_q     <= 1'b0;
			carry_q     <= '0;
			v_s1        <= 1'b0;
			w_s1        <= '0;
			res_addr_q  <= '0;
			res_st_q    <= ST_OK;
			m_valid_q   <= 1'b0;
			m_addr_q    <= '0;
			m_st_q      <= ST_OK;
			m_free_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PAGES: pages_q <= cfg_data;
					CFG_FIRST: first_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					wcnt_q <= wcnt_q + AW'(1);
					if (wcnt_q == AW'(WORDS - 1)) begin
						free_q <= (sn_q > sf_q) ? sn_q - sf_q : '0;
						init_resp_q <= 1'b0;
						res_addr_q <= '0;
						res_st_q <= ST_OK;
						state_q <= init_resp_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= opcode_t'(s_axis_tuser);
						need_q <= need_in;
						base_q <= s_axis_tdata[63:32];
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					res_addr_q <= '0;
					res_st_q <= ST_IGNORED;
					v_s1 <= 1'b0;
					carry_q <= '0;
					state_q <= S_RESP;
					case (op_q)
						OP_ALLOC: begin
							if (need_q != '0) begin
								res_st_q <= ST_NOMEM;
								if ((32'(need_q) <= 32'(free_q)) && (lo_alloc < win)) begin
									mode_q <= M_SCAN;
									lo_q <= lo_alloc;
									hi_q <= win;
									rd_addr_q <= page_word(lo_alloc);
									end_addr_q <= page_word(win - PG_W'(1));
									rd_go_q <= 1'b1;
									state_q <= S_WALK;
								end
							end
						end
						OP_FREE: begin
							if (need_q != '0 && base_q != '0) begin
								res_st_q <= ST_OK;
								if (fc_w < lc_w) begin
									mode_q <= M_CLRB;
									lo_q <= PG_W'(fc_w);
									hi_q <= PG_W'(lc_w);
									rd_addr_q <= page_word(PG_W'(fc_w));
									end_addr_q <= page_word(PG_W'(lc_w - FW'(1)));
									rd_go_q <= 1'b1;
									state_q <= S_WALK;
								end
							end
						end
						OP_INIT: begin
							sf_q <= first_q;
							sn_q <= win;
							wcnt_q <= '0;
							init_resp_q <= 1'b1;
							state_q <= S_CLR;
						end
						default: ;
					endcase
				end
				S_WALK: begin
					v_s1 <= mem_re && !redirect;
					w_s1 <= rd_addr_q;
					if (mem_re) begin
						rd_addr_q <= rd_addr_q + AW'(1);
						if (rd_addr_q == end_addr_q) begin
							rd_go_q <= 1'b0;
						end
					end
					if (v_s1) begin
						case (mode_q)
							M_SCAN: begin
								carry_q <= scan.carry;
								if (scan.hit) begin
									// run found: go back and mark it
									start_q <= hit_start;
									lo_q <= hit_start;
									hi_q <= hit_idx + PG_W'(1);
									rd_addr_q <= page_word(hit_start);
									end_addr_q <= page_word(hit_idx);
									rd_go_q <= 1'b1;
									mode_q <= M_SET;
								end else if (walk_last) begin
									res_st_q <= ST_NOMEM;
									state_q <= S_RESP;
								end
							end
							M_SET: begin
								if (walk_last) begin
									free_q <= free_q - PG_W'(need_q);
									res_addr_q <= 32'(start_q) << PAGE_SHIFT;
									res_st_q <= ST_OK;
									state_q <= S_RESP;
								end
							end
							M_CLRB: begin
								free_q <= free_q + pop;
								if (walk_last) begin
									res_st_q <= ST_OK;
									state_q <= S_RESP;
								end
							end
							default: ;
						endcase
					end
				end
				S_RESP: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_addr_q <= res_addr_q;
						m_st_q <= res_st_q;
						m_free_q <= free_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "page_frame_allocator_core_assert.svh"

	`PFA_NEVER(a_rw_same_word, mem_we && mem_re && (mem_wa == mem_ra), "map word read and written together")
	`PFA_ASSERT(a_set_only_free, (mem_we && state_q == S_WALK && mode_q == M_SET) |-> ((rd_data_s1 & wmask) == '0), "allocation marks a page already taken")
	`PFA_ASSERT(a_free_grows, (state_q == S_WALK && mode_q == M_CLRB) |=> (free_q >= $past(free_q)), "free count dropped while releasing")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives alloc, free, reinit and no-op requests into the page frame allocator
// under several window and reserved-page settings, predicts every response
// with a local copy of the page map and free count, and checks each response
// in order; both stream sides idle in random bursts and the response side
// holds off once for a long stretch so that the request side stalls
// ----------------------------------------------------------------------------
module testbench import pfa_pkg::*; ();

	localparam int STALL_LIMIT = 50000;

	typedef struct packed {
		logic [31:0] addr;
		status_t     st;
		logic [16:0] free_pages;
	} frame_result_t;

	typedef struct {
		logic [31:0] base;
		logic [31:0] size;
	} granted_run_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [16:0] cfg_data;

	bit            page_taken [MAX_PAGES];
	longint        free_frames;
	logic [16:0]   reg_pages;
	logic [16:0]   reg_first;
	frame_result_t pending_results [$];
	granted_run_t  granted_runs [$];
	int            mismatches;
	bit            sender_idle;
	bit            receiver_idle;
	int            hold_off_len;

	page_frame_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// page map prediction

	function automatic longint window_pages();
		longint n;
		n = reg_pages;
		if (n > WIN_MAX) n = WIN_MAX;
		return n;
	endfunction

	function automatic longint pages_for(input logic [31:0] bytes);
		longint b;
		b = bytes;
		return (b + (64'd1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
	endfunction

	task automatic rebuild_page_map();
		longint n;
		n = window_pages();
		free_frames = 0;
		for (int i = 0; i < MAX_PAGES; i++) begin
			page_taken[i] = (i < reg_first) || (i >= n);
			if (!page_taken[i]) free_frames++;
		end
	endtask

	task automatic predict_alloc(input logic [31:0] bytes, output logic [31:0] addr,
			output status_t st);
		longint need, n, lo, i, run, start;
		addr = '0;
		st = ST_NOMEM;
		if (bytes == 0) begin
			st = ST_IGNORED;
			return;
		end
		need = pages_for(bytes);
		if (need > free_frames) return;
		n = window_pages();
		lo = (reg_first < 1) ? 1 : reg_first;
		run = 0;
		start = 0;
		i = lo;
		while (i < n && run != need) begin
			if (!page_taken[i]) begin
				if (run == 0) start = i;
				run++;
			end else begin
				run = 0;
			end
			i++;
		end
		if (run != need) return;
		for (i = start; i < start + need; i++) page_taken[i] = 1'b1;
		free_frames -= need;
		st = ST_OK;
		addr = 32'(start << PAGE_SHIFT);
	endtask

	task automatic predict_free(input logic [31:0] base, input logic [31:0] bytes,
			output status_t st);
		longint n, first, last;
		if (base == 0 || bytes == 0) begin
			st = ST_IGNORED;
			return;
		end
		n = window_pages();
		first = base >> PAGE_SHIFT;
		last = first + pages_for(bytes);
		if (last > n) last = n;
		if (first < reg_first) first = reg_first;
		for (longint i = first; i < last; i++) begin
			if (page_taken[i]) begin
				page_taken[i] = 1'b0;
				free_frames++;
			end
		end
		st = ST_OK;
	endtask

	task automatic record_request(input opcode_t op, input logic [31:0] size,
			input logic [31:0] base);
		frame_result_t r;
		granted_run_t  g;
		r.addr = '0;
		r.st = ST_IGNORED;
		case (op)
			OP_ALLOC: begin
				predict_alloc(size, r.addr, r.st);
				if (r.st == ST_OK) begin
					g.base = r.addr;
					g.size = size;
					granted_runs.push_back(g);
				end
			end
			OP_FREE: predict_free(base, size, r.st);
			OP_INIT: begin
				rebuild_page_map();
				granted_runs.delete();
				r.st = ST_OK;
			end
			default: ;
		endcase
		r.free_pages = (free_frames > 131071) ? 17'h1FFFF : 17'(free_frames);
		pending_results.push_back(r);
	endtask

	// request side

	task automatic send_request(input opcode_t op, input logic [31:0] size,
			input logic [31:0] base);
		@(negedge clk);
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {base, size};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		record_request(op, size, base);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [16:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_PAGES) reg_pages = value;
		else reg_first = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic [16:0] pages, input logic [16:0] first,
			input bit reinit);
		drain_results();
		write_register(CFG_PAGES, pages);
		write_register(CFG_FIRST, first);
		if (reinit) send_request(OP_INIT, $urandom, $urandom);
	endtask

	// mostly alloc and free of granted runs, with some noise and broken requests
	task automatic issue_random_request();
		int unsigned pick, k;
		longint      win;
		logic [31:0] size, base;
		opcode_t     op;
		pick = $urandom_range(0, 99);
		win = window_pages();
		size = '0;
		base = '0;
		op = OP_ALLOC;
		if (granted_runs.size() > 40) pick = 60;
		if (pick < 50) begin
			if ($urandom_range(0, 19) == 0) size = $urandom;
			else if ($urandom_range(0, 9) == 0) size = $urandom_range(1, 64 << PAGE_SHIFT);
			else size = ($urandom_range(0, 7) << PAGE_SHIFT) + $urandom_range(1, 1 << PAGE_SHIFT);
		end else if (pick < 88) begin
			op = OP_FREE;
			if (pick < 80 && granted_runs.size() != 0) begin
				k = $urandom_range(0, granted_runs.size() - 1);
				base = granted_runs[k].base;
				size = granted_runs[k].size;
				granted_runs.delete(k);
				if ($urandom_range(0, 3) == 0) base |= $urandom_range(0, (1 << PAGE_SHIFT) - 1);
				if ($urandom_range(0, 5) == 0) size = $urandom_range(1, size);
			end else begin
				base = ($urandom_range(0, 32'(win)) << PAGE_SHIFT) | $urandom_range(0, 4095);
				size = $urandom_range(1, 16 << PAGE_SHIFT);
			end
		end else if (pick < 96) begin
			op = opcode_t'($urandom_range(0, 3));
			size = $urandom;
			base = $urandom;
		end else begin
			case ($urandom_range(0, 3))
				0: size = '0;
				1: begin
					op = OP_FREE;
					base = $urandom | 32'd1;
				end
				2: begin
					op = OP_FREE;
					size = $urandom;
				end
				default: begin
					op = OP_NOP;
					size = $urandom;
					base = $urandom;
				end
			endcase
		end
		send_request(op, size, base);
	endtask

	// response side

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_len - 1) @(negedge clk);
				hold_off_len = 0;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		frame_result_t exp_r;
		frame_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.addr = m_axis_tdata[31:0];
				got.free_pages = m_axis_tdata[48:32];
				got.st = status_t'(m_axis_tuser);
				if (pending_results.size() == 0) begin
					$display("%0t: response with no request waiting: addr %h status %0d free %0d",
						$time, got.addr, got.st, got.free_pages);
					mismatches++;
				end else begin
					exp_r = pending_results.pop_front();
					if (got.addr !== exp_r.addr) begin
						$display("%0t: first_address expected %h actual %h",
							$time, exp_r.addr, got.addr);
						mismatches++;
					end
					if (got.st !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
						mismatches++;
					end
					if (got.free_pages !== exp_r.free_pages) begin
						$display("%0t: free_pages expected %0d actual %0d",
							$time, exp_r.free_pages, got.free_pages);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// tests

	task automatic test_reset_config_directed();
		send_request(OP_ALLOC, 32'd1, 32'd0);
		send_request(OP_ALLOC, 32'd0, 32'd0);
		send_request(OP_ALLOC, 32'd4096, 32'd0);
		send_request(OP_ALLOC, 32'd4097, 32'd0);
		send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_FREE, 32'd4096, 32'd0);
		send_request(OP_FREE, 32'd0, 32'h0010_1000);
		send_request(OP_FREE, 32'd1, 32'h0010_1ABC);
		send_request(OP_FREE, 32'd4096, 32'h0010_1000);
		send_request(OP_FREE, 32'h0010_0000, 32'h0000_1000);
		send_request(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_F000);
		send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, 32'd4096, 32'd0);
		send_request(OP_INIT, 32'd0, 32'd0);
		// take every free frame in one run, then release the whole window
		send_request(OP_ALLOC, 32'h0FF0_0000, 32'd0);
		send_request(OP_ALLOC, 32'd1, 32'd0);
		send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0010_0000);
	endtask

	task automatic test_frame_zero_and_fragments();
		apply_config(17'd8, 17'd0, 1'b1);
		send_request(OP_ALLOC, 32'h0000_8000, 32'd0);
		send_request(OP_ALLOC, 32'd4096, 32'd0);
		send_request(OP_ALLOC, 32'd4096, 32'd0);
		send_request(OP_ALLOC, 32'd4096, 32'd0);
		send_request(OP_FREE, 32'd4096, 32'h0000_2000);
		send_request(OP_ALLOC, 32'd8192, 32'd0);
		send_request(OP_ALLOC, 32'd12288, 32'd0);
	endtask

	task automatic test_random_default_window();
		apply_config(17'd65536, 17'd256, 1'b1);
		repeat (300) issue_random_request();
	endtask

	task automatic test_random_tiny_window();
		apply_config(17'd64, 17'd0, 1'b1);
		repeat (250) issue_random_request();
	endtask

	task automatic test_random_mid_window();
		apply_config(17'd1000, 17'd17, 1'b1);
		repeat (250) issue_random_request();
	endtask

	task automatic test_clipped_window();
		apply_config(17'h1FFFF, 17'd65535, 1'b1);
		repeat (100) issue_random_request();
	endtask

	task automatic test_no_usable_frames();
		apply_config(17'd0, 17'd65536, 1'b1);
		repeat (30) issue_random_request();
		apply_config(17'd1, 17'd0, 1'b1);
		repeat (30) issue_random_request();
	endtask

	task automatic test_stale_registers();
		apply_config(17'd300, 17'd40, 1'b0);
		repeat (150) issue_random_request();
	endtask

	task automatic test_output_backpressure();
		apply_config(17'd65536, 17'd1, 1'b1);
		hold_off_len = 400;
		repeat (40) issue_random_request();
	endtask

	task automatic test_random_no_idle();
		apply_config(17'd2048, 17'd256, 1'b1);
		drain_results();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		repeat (250) issue_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_NOP;
		cfg_valid = 1'b0;
		cfg_index = CFG_PAGES;
		cfg_data = '0;
		mismatches = 0;
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		hold_off_len = 0;
		reg_pages = 17'(PAGES_RST);
		reg_first = 17'(FIRST_RST);
		rebuild_page_map();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_config_directed();
		test_frame_zero_and_fragments();
		test_random_default_window();
		test_random_tiny_window();
		test_random_mid_window();
		test_clipped_window();
		test_no_usable_frames();
		test_stale_registers();
		test_output_backpressure();
		test_random_no_idle();

		drain_results();
		repeat (64) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
